### rtl/core/assert_macros.svh
// Assertion macros shared by the filter RTL; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, switched off while reset is asserted.
`define CAT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cat filter: assertion violated");
// Clocked check that also holds through reset.
`define CAT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("cat filter: assertion violated");
`else
`define CAT_ASSERT(lbl, clk, rst_n, prop)
`define CAT_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### rtl/core/cat_pkg.sv
// Package: constants, character codes and the job descriptor of the text filter.
package cat_pkg;

    // line number width
    localparam int unsigned NUMBER_DIGITS = 6;
    localparam int unsigned BCD_W         = 4 * NUMBER_DIGITS;
    localparam int unsigned DIG_W         = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;
    localparam logic [DIG_W-1:0] DIG_TOP  = DIG_W'(NUMBER_DIGITS - 1);

    // job queue between front and back
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam logic [FIFO_AW-1:0] FIFO_PTR_ONE  = FIFO_AW'(1);
    localparam logic [FIFO_AW:0]   FIFO_CNT_ONE  = (FIFO_AW + 1)'(1);
    localparam logic [FIFO_AW:0]   FIFO_FULL_CNT = (FIFO_AW + 1)'(FIFO_DEPTH);

    // configuration register indexes
    localparam logic [2:0] CFG_NUMBER_MODE      = 3'd0;
    localparam logic [2:0] CFG_SQUEEZE_BLANK    = 3'd1;
    localparam logic [2:0] CFG_SHOW_ENDS        = 3'd2;
    localparam logic [2:0] CFG_SHOW_TABS        = 3'd3;
    localparam logic [2:0] CFG_SHOW_NONPRINTING = 3'd4;

    // numbering modes; the spare code means no numbering
    localparam logic [1:0] NUM_ALL      = 2'd1;
    localparam logic [1:0] NUM_NONBLANK = 2'd2;

    // character codes
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_NL     = 8'd10;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_DOLLAR = 8'd36;
    localparam logic [7:0] CH_DASH   = 8'd45;
    localparam logic [7:0] CH_ZERO   = 8'd48;
    localparam logic [7:0] CH_QMARK  = 8'd63;
    localparam logic [7:0] CH_I      = 8'd73;
    localparam logic [7:0] CH_M      = 8'd77;
    localparam logic [7:0] CH_CARET  = 8'd94;
    localparam logic [7:0] CH_TILDE  = 8'd126;
    localparam logic [7:0] CH_DEL    = 8'd127;
    localparam logic [7:0] CARET_OFS = 8'd64;

    localparam int unsigned BODY_MAX = 4;

    // one kept input byte, fully classified
    typedef struct packed {
        logic                         pfx;      // emit line number prefix
        logic [BCD_W-1:0]             bcd;      // line number after the bump
        logic                         dollar;   // emit '$' before the body
        logic [2:0]                   body_cnt; // 1..4 body bytes
        logic [BODY_MAX-1:0][7:0]     body;
    } t_job;

endpackage

### rtl/core/cat_front.sv
// Front end: config registers, line state, classification into job descriptors.
`include "assert_macros.svh"

module cat_front import cat_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [1:0] i_cfg_data,
    input  logic       i_in_valid,
    input  logic [7:0] i_in_byte,
    input  logic       i_full,
    output logic       o_in_stall,
    output logic       o_push,
    output t_job       o_job
);

    logic [1:0]       r_mode;
    logic             r_squeeze;
    logic             r_show_ends;
    logic             r_show_tabs;
    logic             r_show_np;
    logic             r_prev_nl;
    logic [1:0]       r_nl_run;
    logic [BCD_W-1:0] r_bcd;

    logic [1:0]       n_nl_run;
    logic [BCD_W-1:0] n_bcd;
    logic             accept;
    logic             is_nl;
    logic             keep;
    logic             pfx;
    logic [7:0]       low;

    function automatic logic [BCD_W-1:0] bcd_bump(input logic [BCD_W-1:0] v);
        logic [BCD_W-1:0] r;
        logic             carry;
        logic             nines;
        r     = v;
        carry = 1'b1;
        nines = 1'b1;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            if (v[4*i +: 4] != 4'd9) nines = 1'b0;
        end
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            if (carry) begin
                if (v[4*i +: 4] >= 4'd9) begin
                    r[4*i +: 4] = 4'd0;
                end else begin
                    r[4*i +: 4] = v[4*i +: 4] + 4'd1;
                    carry       = 1'b0;
                end
            end
        end
        return nines ? v : r;
    endfunction

    function automatic logic [7:0] caret(input logic [7:0] c);
        return (c == CH_DEL) ? CH_QMARK : c + CARET_OFS;
    endfunction

    assign o_in_stall = i_full;
    assign accept     = i_in_valid && !i_full;
    assign o_push     = accept && keep;

    always_comb begin
        is_nl    = (i_in_byte == CH_NL);
        n_nl_run = r_nl_run;
        keep     = 1'b1;
        if (r_squeeze) begin
            if (is_nl) begin
                if (r_nl_run != 2'd3) n_nl_run = r_nl_run + 2'd1;
            end else begin
                n_nl_run = 2'd0;
            end
            keep = !(is_nl && (n_nl_run == 2'd3));
        end
        pfx   = keep && r_prev_nl &&
                (((r_mode == NUM_NONBLANK) && !is_nl) || (r_mode == NUM_ALL));
        n_bcd = pfx ? bcd_bump(r_bcd) : r_bcd;
        low   = {1'b0, i_in_byte[6:0]};

        o_job.pfx      = pfx;
        o_job.bcd      = n_bcd;
        o_job.dollar   = r_show_ends && is_nl;
        o_job.body_cnt = 3'd1;
        o_job.body     = '0;
        o_job.body[0]  = i_in_byte;
        priority if ((i_in_byte >= CH_SPACE) && (i_in_byte <= CH_TILDE)) begin
            o_job.body[0] = i_in_byte;
        end else if (i_in_byte == CH_TAB) begin
            if (r_show_tabs) begin
                o_job.body[0]  = CH_CARET;
                o_job.body[1]  = CH_I;
                o_job.body_cnt = 3'd2;
            end
        end else if (is_nl) begin
            o_job.body[0] = i_in_byte;
        end else if ((i_in_byte < CH_SPACE) || (i_in_byte == CH_DEL)) begin
            if (r_show_np) begin
                o_job.body[0]  = CH_CARET;
                o_job.body[1]  = caret(i_in_byte);
                o_job.body_cnt = 3'd2;
            end
        end else if (r_show_np) begin
            // high byte: M- then the low seven bits
            o_job.body[0] = CH_M;
            o_job.body[1] = CH_DASH;
            if ((low >= CH_SPACE) && (low <= CH_TILDE)) begin
                o_job.body[2]  = low;
                o_job.body_cnt = 3'd3;
            end else begin
                o_job.body[2]  = CH_CARET;
                o_job.body[3]  = caret(low);
                o_job.body_cnt = 3'd4;
            end
        end else begin
            o_job.body[0] = i_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= '0;
            r_squeeze   <= 1'b0;
            r_show_ends <= 1'b0;
            r_show_tabs <= 1'b0;
            r_show_np   <= 1'b0;
            r_prev_nl   <= 1'b1;
            r_nl_run    <= 2'd1;
            r_bcd       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_NUMBER_MODE:      r_mode      <= i_cfg_data;
                    CFG_SQUEEZE_BLANK:    r_squeeze   <= i_cfg_data[0];
                    CFG_SHOW_ENDS:        r_show_ends <= i_cfg_data[0];
                    CFG_SHOW_TABS:        r_show_tabs <= i_cfg_data[0];
                    CFG_SHOW_NONPRINTING: r_show_np   <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_prev_nl <= is_nl;
                r_nl_run  <= n_nl_run;
                r_bcd     <= n_bcd;
            end
        end
    end

    `CAT_ASSERT(a_front_prev_nl, i_clk, i_rst_n, accept |=> (r_prev_nl == $past(is_nl)))
    `CAT_ASSERT(a_front_no_squeeze_keeps, i_clk, i_rst_n, (accept && !r_squeeze) |-> o_push)
    `CAT_ASSERT(a_front_third_nl_dropped, i_clk, i_rst_n, (accept && r_squeeze && is_nl && (r_nl_run >= 2'd2)) |-> !o_push)

endmodule

### rtl/core/cat_fifo.sv
// Short job queue between front and back, register based.
`include "assert_macros.svh"

module cat_fifo import cat_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_head
);

    t_job               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr;
    logic [FIFO_AW-1:0] r_rd;
    logic [FIFO_AW:0]   r_cnt;

    assign o_full  = (r_cnt == FIFO_FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + FIFO_PTR_ONE;
            if (i_pop)  r_rd <= r_rd + FIFO_PTR_ONE;
            if (i_push && !i_pop)      r_cnt <= r_cnt + FIFO_CNT_ONE;
            else if (i_pop && !i_push) r_cnt <= r_cnt - FIFO_CNT_ONE;
        end
    end

    `CAT_ASSERT(a_fifo_no_overflow, i_clk, i_rst_n, i_push |-> !o_full)
    `CAT_ASSERT(a_fifo_no_underflow, i_clk, i_rst_n, i_pop |-> !o_empty)
    `CAT_ASSERT(a_fifo_cnt_range, i_clk, i_rst_n, r_cnt <= FIFO_FULL_CNT)
    `CAT_ASSERT(a_fifo_cnt_up, i_clk, i_rst_n, (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + FIFO_CNT_ONE))

endmodule

### rtl/core/cat_back.sv
// Back end: turns the head job into registered output bytes, one per cycle unless stalled.
`include "assert_macros.svh"

module cat_back import cat_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_job       i_head,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last
);

    typedef enum logic [1:0] {
        PH_DIGIT,
        PH_TAB,
        PH_END,
        PH_BODY
    } t_phase;

    logic       r_busy;
    t_phase     r_phase;
    logic [DIG_W-1:0] r_dig;
    logic [1:0] r_bidx;

    t_phase     cur_phase;
    logic [DIG_W-1:0] cur_dig;
    logic [1:0] cur_bidx;
    t_phase     n_phase;
    logic [DIG_W-1:0] n_dig;
    logic [1:0] n_bidx;
    logic       is_last;
    logic       emit;
    logic [7:0] byte_sel;
    logic [3:0] digit;
    logic [NUMBER_DIGITS-1:0] lead;
    logic       zeros;

    assign emit  = !i_empty && (!o_out_valid || !i_out_stall);
    assign o_pop = emit && is_last;

    always_comb begin
        // leading zeros of the number print as spaces, the units digit never does
        zeros = 1'b1;
        for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
            zeros   = zeros && (i_head.bcd[4*i +: 4] == 4'd0);
            lead[i] = zeros && (i != 0);
        end

        if (r_busy) begin
            cur_phase = r_phase;
            cur_dig   = r_dig;
            cur_bidx  = r_bidx;
        end else begin
            cur_phase = i_head.pfx ? PH_DIGIT : (i_head.dollar ? PH_END : PH_BODY);
            cur_dig   = DIG_TOP;
            cur_bidx  = 2'd0;
        end

        digit    = i_head.bcd[4*cur_dig +: 4];
        n_phase  = cur_phase;
        n_dig    = cur_dig;
        n_bidx   = cur_bidx;
        is_last  = 1'b0;
        byte_sel = CH_SPACE;
        unique case (cur_phase)
            PH_DIGIT: begin
                byte_sel = lead[cur_dig] ? CH_SPACE : CH_ZERO + {4'd0, digit};
                if (cur_dig == '0) n_phase = PH_TAB;
                else               n_dig   = cur_dig - DIG_W'(1);
            end
            PH_TAB: begin
                byte_sel = CH_TAB;
                n_phase  = i_head.dollar ? PH_END : PH_BODY;
                n_bidx   = 2'd0;
            end
            PH_END: begin
                byte_sel = CH_DOLLAR;
                n_phase  = PH_BODY;
                n_bidx   = 2'd0;
            end
            PH_BODY: begin
                byte_sel = i_head.body[cur_bidx];
                is_last  = ({1'b0, cur_bidx} + 3'd1) == i_head.body_cnt;
                n_bidx   = cur_bidx + 2'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= PH_DIGIT;
            r_dig       <= DIG_TOP;
            r_bidx      <= 2'd0;
            o_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_busy      <= !is_last;
                r_phase     <= n_phase;
                r_dig       <= n_dig;
                r_bidx      <= n_bidx;
                o_out_valid <= 1'b1;
                o_out_byte  <= byte_sel;
                o_last      <= is_last;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    `CAT_ASSERT(a_back_busy_has_job, i_clk, i_rst_n, r_busy |-> !i_empty)
    `CAT_ASSERT(a_back_stall_no_pop, i_clk, i_rst_n, (o_out_valid && i_out_stall) |-> !o_pop)
    `CAT_ASSERT(a_back_digit_needs_pfx, i_clk, i_rst_n, (r_busy && (r_phase == PH_DIGIT)) |-> i_head.pfx)
    `CAT_ASSERT(a_back_pop_ends_job, i_clk, i_rst_n, o_pop |=> !r_busy)

endmodule

### rtl/core/cat_text_stream_filter.sv
// Top level of the byte-stream text filter (line numbers, squeeze, $ ends, caret/M- forms).
//
//  channel  dir  handshake                     payload
//  -------  ---  ----------------------------  ----------------------
//  in       in   i_in_valid / o_in_stall       i_in_byte
//  out      out  o_out_valid / i_out_stall     o_out_byte, o_last
//  cfg      in   i_cfg_we (no wait)            i_cfg_idx, i_cfg_data
//
// Rate: the back end emits one byte per cycle while a job is queued and i_out_stall is
//   low; an input byte expands to 0 to 11 output bytes (a dropped newline to none); a
//   plain byte passes at one transaction per cycle while the output does not stall.
// A job is written to the queue first; its first output byte is then registered.
// A four-entry job queue separates front and back; o_in_stall is high while it is full.
// Reset: synchronous, active low; no clearing pass.
// o_out_valid holds with its byte while i_out_stall is high.

module cat_text_stream_filter import cat_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [1:0] i_cfg_data,
    // input stream
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    // output stream
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last
);

    // front to queue
    logic push;
    t_job job;
    // queue to back
    logic full;
    logic empty;
    logic pop;
    t_job head;

    // classify each byte and keep the line state; dropped newlines never reach the queue
    cat_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .i_in_byte  (i_in_byte),
        .i_full     (full),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_job      (job)
    );

    // jobs waiting to be expanded
    cat_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    // expansion: prefix digits, tab, '$', body; pops the job on its final byte
    cat_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the cat_text_stream_filter byte-stream text filter.
module testbench;
    import cat_pkg::*;

    // Number modes the package leaves unnamed: off and the spare code.
    localparam logic [1:0] NUM_NONE  = 2'd0;
    localparam logic [1:0] NUM_SPARE = 2'd3;

    // Quiet cycles tolerated before the run is declared hung. The slowest
    // transaction is 11 output bytes under random stall.
    localparam int QUIET_LIMIT = 2000;
    // Cycles left after the last result so that the filter is fully idle
    // before a register changes.
    localparam int SETTLE_CYCLES = 12;

    // Directed bytes: every byte class and a four-newline run.
    localparam int DIRECTED_N = 23;
    localparam logic [7:0] DIRECTED [DIRECTED_N] = '{
        8'h41, CH_TAB, CH_NL, CH_NL, CH_NL, CH_NL, 8'h00, 8'h1F, CH_DEL,
        8'h80, 8'h89, 8'h9F, 8'hFF, 8'hA0, 8'hFE, CH_SPACE, CH_TILDE,
        CH_NL, CH_NL, 8'h78, CH_NL, 8'h0A, 8'h7E
    };

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_beat_t;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [2:0] i_cfg_idx   = CFG_NUMBER_MODE;
    logic [1:0] i_cfg_data  = 2'd0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_in_byte   = 8'd0;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_last;

    cat_text_stream_filter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_byte   (i_in_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

    always #5 i_clk = ~i_clk;

    // Bytes waiting to be offered, and bytes the filter still owes us.
    logic [7:0] byte_pending [$];
    out_beat_t  expected_bytes [$];

    // Shadow of the configuration registers.
    logic [1:0] cfg_mode    = NUM_NONE;
    logic       cfg_squeeze = 1'b0;
    logic       cfg_ends    = 1'b0;
    logic       cfg_tabs    = 1'b0;
    logic       cfg_nonprt  = 1'b0;

    // Shadow of the line state.
    logic             line_start = 1'b1;
    logic [1:0]       nl_run     = 2'd1;
    logic [BCD_W-1:0] line_bcd   = '0;

    int idle_pct      = 36;
    int quiet_cycles  = 0;
    int mismatches    = 0;
    int bytes_in      = 0;
    int bytes_out     = 0;
    int settings_used = 0;
    logic in_taken    = 1'b0;

    // Second byte of caret form: ^? for DEL, otherwise the byte plus 64.
    function automatic logic [7:0] caret_of(input logic [7:0] c);
        return (c == CH_DEL) ? CH_QMARK : c + CARET_OFS;
    endfunction

    // Works out the output bytes for one input byte and queues them,
    // advancing the shadow line state on the way.
    task automatic filter_byte(input logic [7:0] c);
        logic [7:0] outq [$];
        logic       is_nl;
        logic       keep;
        logic       all_nines;
        logic       carry;
        logic       leading;
        logic [3:0] d;
        logic [7:0] low;
        out_beat_t  beat;
        int         k;
        is_nl = (c == CH_NL);
        keep  = 1'b1;

        // Squeeze: count newlines in a row, saturating at three; the
        // count is frozen while squeeze is off.
        if (cfg_squeeze) begin
            if (is_nl) begin
                if (nl_run < 2'd3) nl_run = nl_run + 2'd1;
            end else begin
                nl_run = 2'd0;
            end
            if (is_nl && nl_run > 2'd2) keep = 1'b0;
        end

        if (keep) begin
            if ((cfg_mode == NUM_NONBLANK && line_start && !is_nl) ||
                (cfg_mode == NUM_ALL && line_start)) begin
                // Bump the BCD counter, holding at all nines.
                all_nines = 1'b1;
                for (k = 0; k < NUMBER_DIGITS; k++)
                    if (line_bcd[4*k +: 4] != 4'd9) all_nines = 1'b0;
                if (!all_nines) begin
                    carry = 1'b1;
                    for (k = 0; k < NUMBER_DIGITS; k++) begin
                        if (carry) begin
                            if (line_bcd[4*k +: 4] >= 4'd9) begin
                                line_bcd[4*k +: 4] = 4'd0;
                            end else begin
                                line_bcd[4*k +: 4] = line_bcd[4*k +: 4] + 4'd1;
                                carry = 1'b0;
                            end
                        end
                    end
                end
                // Right-justified digits, spaces for leading zeros, then a tab.
                leading = 1'b1;
                for (k = NUMBER_DIGITS - 1; k >= 0; k--) begin
                    d = line_bcd[4*k +: 4];
                    if (d != 4'd0 || k == 0) leading = 1'b0;
                    outq.push_back(leading ? CH_SPACE : CH_ZERO + {4'd0, d});
                end
                outq.push_back(CH_TAB);
            end

            if (cfg_ends && is_nl) outq.push_back(CH_DOLLAR);

            if (c >= CH_SPACE && c <= CH_TILDE) begin
                outq.push_back(c);
            end else if (c == CH_TAB) begin
                if (cfg_tabs) begin
                    outq.push_back(CH_CARET);
                    outq.push_back(CH_I);
                end else begin
                    outq.push_back(c);
                end
            end else if (is_nl) begin
                outq.push_back(c);
            end else if (c < CH_SPACE || c == CH_DEL) begin
                if (cfg_nonprt) begin
                    outq.push_back(CH_CARET);
                    outq.push_back(caret_of(c));
                end else begin
                    outq.push_back(c);
                end
            end else if (cfg_nonprt) begin
                // High byte: M- then the low seven bits, caret form if needed.
                low = {1'b0, c[6:0]};
                outq.push_back(CH_M);
                outq.push_back(CH_DASH);
                if (low >= CH_SPACE && low <= CH_TILDE) begin
                    outq.push_back(low);
                end else begin
                    outq.push_back(CH_CARET);
                    outq.push_back(caret_of(low));
                end
            end else begin
                outq.push_back(c);
            end
        end

        // A dropped newline still counts as the end of a line.
        line_start = is_nl;

        for (k = 0; k < outq.size(); k++) begin
            beat.data = outq[k];
            beat.last = (k == outq.size() - 1);
            expected_bytes.push_back(beat);
        end
    endtask

    // Sender: a new transaction is offered only once the previous one has
    // gone; a stalled byte is held untouched.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (byte_pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_byte  <= byte_pending.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, independent of o_out_valid.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    // Monitor: the result is checked before the input transaction of the
    // same edge is predicted, so an unexpected byte is never hidden.
    always @(posedge i_clk) begin : monitor
        out_beat_t want;
        logic      out_taken;
        in_taken  = i_rst_n && i_in_valid && !o_in_stall;
        out_taken = i_rst_n && o_out_valid && !i_out_stall;
        if (out_taken) begin
            bytes_out++;
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected output, expected none, actual byte %h last %b",
                         $time, o_out_byte, o_last);
                mismatches++;
            end else begin
                want = expected_bytes.pop_front();
                if (o_out_byte !== want.data) begin
                    $display("%0t: out_byte expected %h, actual %h",
                             $time, want.data, o_out_byte);
                    mismatches++;
                end
                if (o_last !== want.last) begin
                    $display("%0t: last expected %b, actual %b", $time, want.last, o_last);
                    mismatches++;
                end
            end
        end
        if (in_taken) begin
            bytes_in++;
            filter_byte(i_in_byte);
        end
        if (in_taken || out_taken || !i_rst_n) quiet_cycles = 0;
        else quiet_cycles++;
    end

    // Watchdog on transaction activity.
    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    task automatic write_reg(input logic [2:0] idx, input logic [1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
    endtask

    // Writes every register and updates the shadow copy; only called idle.
    task automatic apply_settings(input logic [1:0] mode, input logic sq, input logic ends,
                                  input logic tabs, input logic nonprt);
        write_reg(CFG_NUMBER_MODE, mode);
        write_reg(CFG_SQUEEZE_BLANK, {1'b0, sq});
        write_reg(CFG_SHOW_ENDS, {1'b0, ends});
        write_reg(CFG_SHOW_TABS, {1'b0, tabs});
        write_reg(CFG_SHOW_NONPRINTING, {1'b0, nonprt});
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_mode    = mode;
        cfg_squeeze = sq;
        cfg_ends    = ends;
        cfg_tabs    = tabs;
        cfg_nonprt  = nonprt;
        settings_used++;
        @(posedge i_clk);
    endtask

    // Waits until every byte is sent and every result has come back.
    task automatic wait_drained(input int settle);
        while (byte_pending.size() != 0 || i_in_valid || expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // Mostly text-like content: printable with some tabs, control and high bytes.
    function automatic logic [7:0] text_char();
        int r;
        r = $urandom_range(99);
        if (r < 70) return 8'($urandom_range(32, 126));
        if (r < 78) return CH_TAB;
        if (r < 85) return 8'($urandom_range(0, 31));
        if (r < 90) return CH_DEL;
        return 8'($urandom_range(128, 255));
    endfunction

    // Queues about n bytes: lines with content, runs of blank lines and
    // now and then a raw byte of any value.
    task automatic queue_text(input int n);
        int added;
        int r;
        int len;
        int k;
        added = 0;
        while (added < n) begin
            r = $urandom_range(99);
            if (r < 15) begin
                len = $urandom_range(1, 4);
                for (k = 0; k < len; k++) byte_pending.push_back(CH_NL);
                added += len;
            end else if (r < 85) begin
                len = $urandom_range(1, 8);
                for (k = 0; k < len; k++) byte_pending.push_back(text_char());
                byte_pending.push_back(CH_NL);
                added += len + 1;
            end else begin
                byte_pending.push_back(8'($urandom));
                added++;
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every byte class, squeeze of a four-newline run, and
        // the nonblank numbering skipping blank lines.
        apply_settings(NUM_NONBLANK, 1'b1, 1'b1, 1'b1, 1'b1);
        foreach (DIRECTED[k]) byte_pending.push_back(DIRECTED[k]);
        wait_drained(SETTLE_CYCLES);

        // Same bytes with every option off: straight pass-through.
        apply_settings(NUM_NONE, 1'b0, 1'b0, 1'b0, 1'b0);
        foreach (DIRECTED[k]) byte_pending.push_back(DIRECTED[k]);
        wait_drained(SETTLE_CYCLES);

        apply_settings(NUM_ALL, 1'b1, 1'b1, 1'b1, 1'b1);
        queue_text(20);
        wait_drained(SETTLE_CYCLES);

        // A stretch with no idling on either side.
        idle_pct = 0;
        apply_settings(NUM_NONE, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_text(30);
        wait_drained(SETTLE_CYCLES);
        idle_pct = 36;

        apply_settings(NUM_SPARE, 1'b1, 1'b0, 1'b1, 1'b0);
        queue_text(20);
        wait_drained(SETTLE_CYCLES);

        // Sender holds off mid-phase until the filter has caught up.
        apply_settings(NUM_NONBLANK, 1'b0, 1'b1, 1'b0, 1'b1);
        queue_text(10);
        wait_drained(0);
        queue_text(10);
        wait_drained(SETTLE_CYCLES);

        repeat (2) begin
            apply_settings(2'($urandom_range(3)), 1'($urandom_range(1)),
                           1'($urandom_range(1)), 1'($urandom_range(1)),
                           1'($urandom_range(1)));
            queue_text(20);
            wait_drained(SETTLE_CYCLES);
        end

        apply_settings(NUM_ALL, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_text(20);
        wait_drained(SETTLE_CYCLES);

        if (expected_bytes.size() != 0) begin
            $display("%0t: %0d results never arrived, first expected byte %h last %b",
                     $time, expected_bytes.size(), expected_bytes[0].data,
                     expected_bytes[0].last);
            mismatches++;
        end
        $display("Sent %0d bytes, checked %0d output bytes over %0d register settings",
                 bytes_in, bytes_out, settings_used);
        $display("Line counter ended at %h", line_bcd);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
